>>> rtl/tcs_pkg.sv
package tcs_pkg;

  localparam int unsigned COORD_W = 11;
  localparam int unsigned DIFF_W = COORD_W + 1;
  localparam int unsigned PROD_W = 2 * DIFF_W;
  localparam int unsigned EDGE_W = PROD_W + 1;
  localparam int unsigned INDEX_W = 22;
  localparam int unsigned COLOUR_W = 8;
  localparam int unsigned SCALE_W = COORD_W + COLOUR_W;
  localparam int unsigned SPAN_W = COORD_W + 1;
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned NUM_VERTICES = 3;

  localparam int unsigned DEFAULT_VIEW_WIDTH = 1080;
  localparam int unsigned DEFAULT_VIEW_HEIGHT = 720;

  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic [2:0] {
    REG_VERTEX_A_X,
    REG_VERTEX_A_Y,
    REG_VERTEX_B_X,
    REG_VERTEX_B_Y,
    REG_VERTEX_C_X,
    REG_VERTEX_C_Y
  } tcs_reg_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t cx;
    coord_t cy;
    coord_t min_x;
    coord_t max_x;
    coord_t min_y;
    coord_t max_y;
  } tcs_tri_t;

  function automatic coord_t min3(input coord_t a, input coord_t b, input coord_t c);
    coord_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic coord_t max3(input coord_t a, input coord_t b, input coord_t c);
    coord_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

endpackage

>>> rtl/tcs_regs.sv
module tcs_regs
  import tcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output tcs_tri_t           tri_cfg
);

  coord_t ax, ay, bx, by, cx, cy;
  tcs_reg_t reg_sel;
  coord_t wr_value;
  coord_t rd_value;

  assign reg_sel = tcs_reg_t'(paddr[PADDR_W-1:2]);
  assign wr_value = pwdata[COORD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ax <= '0;
      ay <= '0;
      bx <= '0;
      by <= '0;
      cx <= '0;
      cy <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_VERTEX_A_X: ax <= wr_value;
        REG_VERTEX_A_Y: ay <= wr_value;
        REG_VERTEX_B_X: bx <= wr_value;
        REG_VERTEX_B_Y: by <= wr_value;
        REG_VERTEX_C_X: cx <= wr_value;
        REG_VERTEX_C_Y: cy <= wr_value;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_VERTEX_A_X: rd_value = ax;
      REG_VERTEX_A_Y: rd_value = ay;
      REG_VERTEX_B_X: rd_value = bx;
      REG_VERTEX_B_Y: rd_value = by;
      REG_VERTEX_C_X: rd_value = cx;
      REG_VERTEX_C_Y: rd_value = cy;
      default:        rd_value = '0;
    endcase
  end

  assign prdata = PDATA_W'(rd_value);

  always_comb begin
    tri_cfg.ax = ax;
    tri_cfg.ay = ay;
    tri_cfg.bx = bx;
    tri_cfg.by = by;
    tri_cfg.cx = cx;
    tri_cfg.cy = cy;
    tri_cfg.min_x = min3(ax, bx, cx);
    tri_cfg.max_x = max3(ax, bx, cx);
    tri_cfg.min_y = min3(ay, by, cy);
    tri_cfg.max_y = max3(ay, by, cy);
  end

endmodule

>>> rtl/tcs_edge_pipe.sv
module tcs_edge_pipe
  import tcs_pkg::*;
(
  input  logic     clk,
  input  logic     en,
  input  coord_t   pixel_x,
  input  coord_t   pixel_y,
  input  tcs_tri_t tri_cfg,
  output logic     covered
);

  coord_t vx [NUM_VERTICES];
  coord_t vy [NUM_VERTICES];

  logic signed [DIFF_W-1:0] off_x [NUM_VERTICES];
  logic signed [DIFF_W-1:0] off_y [NUM_VERTICES];
  logic signed [DIFF_W-1:0] nrm_x [NUM_VERTICES];
  logic signed [DIFF_W-1:0] nrm_y [NUM_VERTICES];
  logic                     inside1;

  logic signed [PROD_W-1:0] prod_x [NUM_VERTICES];
  logic signed [PROD_W-1:0] prod_y [NUM_VERTICES];
  logic                     inside2;

  logic signed [EDGE_W-1:0] edge_val [NUM_VERTICES];
  logic [NUM_VERTICES-1:0]  edge_pos;
  logic [NUM_VERTICES-1:0]  edge_nonpos;
  logic                     covered_next;

  assign vx[0] = tri_cfg.ax;
  assign vx[1] = tri_cfg.bx;
  assign vx[2] = tri_cfg.cx;
  assign vy[0] = tri_cfg.ay;
  assign vy[1] = tri_cfg.by;
  assign vy[2] = tri_cfg.cy;

  for (genvar k = 0; k < NUM_VERTICES; k++) begin : g_edge
    localparam int unsigned K1 = (k + 1) % NUM_VERTICES;

    always_ff @(posedge clk) begin
      if (en) begin
        off_x[k] <= $signed({1'b0, pixel_x}) - $signed({1'b0, vx[k]});
        off_y[k] <= $signed({1'b0, pixel_y}) - $signed({1'b0, vy[k]});
        nrm_x[k] <= $signed({1'b0, vy[k]}) - $signed({1'b0, vy[K1]});
        nrm_y[k] <= $signed({1'b0, vx[K1]}) - $signed({1'b0, vx[k]});
        prod_x[k] <= off_x[k] * nrm_x[k];
        prod_y[k] <= off_y[k] * nrm_y[k];
      end
    end

    assign edge_val[k] = EDGE_W'(prod_x[k]) + EDGE_W'(prod_y[k]);
    assign edge_pos[k] = !edge_val[k][EDGE_W-1] && (edge_val[k] != '0);
    assign edge_nonpos[k] = !edge_pos[k];
  end

  assign covered_next = inside2 && ((&edge_pos) || (&edge_nonpos));

  always_ff @(posedge clk) begin
    if (en) begin
      inside1 <= (pixel_x >= tri_cfg.min_x) && (pixel_x <= tri_cfg.max_x) &&
                 (pixel_y >= tri_cfg.min_y) && (pixel_y <= tri_cfg.max_y);
      inside2 <= inside1;
      covered <= covered_next;
    end
  end

endmodule

>>> rtl/tcs_shade_pipe.sv
module tcs_shade_pipe
  import tcs_pkg::*;
#(
  parameter int unsigned VIEW_WIDTH = DEFAULT_VIEW_WIDTH,
  parameter int unsigned VIEW_HEIGHT = DEFAULT_VIEW_HEIGHT
) (
  input  logic                clk,
  input  logic                en,
  input  coord_t              pixel_x,
  input  coord_t              pixel_y,
  output logic [INDEX_W-1:0]  frame_index,
  output logic [COLOUR_W-1:0] red,
  output logic [COLOUR_W-1:0] green
);

  localparam int unsigned SHIFT = SCALE_W + SPAN_W;
  localparam int unsigned MULT_W = SHIFT;
  localparam int unsigned QPROD_W = SCALE_W + MULT_W;
  localparam int unsigned QUOT_W = QPROD_W - SHIFT;
  localparam int unsigned IPROD_W = COORD_W + SPAN_W;
  localparam logic [MULT_W-1:0] RED_MULT =
    MULT_W'(((64'd1 << SHIFT) + 64'(VIEW_WIDTH) - 64'd1) / 64'(VIEW_WIDTH));
  localparam logic [MULT_W-1:0] GREEN_MULT =
    MULT_W'(((64'd1 << SHIFT) + 64'(VIEW_HEIGHT) - 64'd1) / 64'(VIEW_HEIGHT));
  localparam logic [SPAN_W-1:0] WIDTH_K = SPAN_W'(VIEW_WIDTH);
  localparam logic [QUOT_W-1:0] COLOUR_MAX = QUOT_W'((1 << COLOUR_W) - 1);

  logic [SCALE_W-1:0] red_scaled;
  logic [SCALE_W-1:0] green_scaled;
  coord_t             col1;
  coord_t             row1;

  logic [QPROD_W-1:0] red_prod;
  logic [QPROD_W-1:0] green_prod;
  logic [IPROD_W-1:0] row_prod;
  coord_t             col2;

  logic [QUOT_W-1:0] red_quot;
  logic [QUOT_W-1:0] green_quot;

  assign red_quot = red_prod[QPROD_W-1:SHIFT];
  assign green_quot = green_prod[QPROD_W-1:SHIFT];

  always_ff @(posedge clk) begin
    if (en) begin
      red_scaled <= (SCALE_W'(pixel_x) << COLOUR_W) - SCALE_W'(pixel_x);
      green_scaled <= (SCALE_W'(pixel_y) << COLOUR_W) - SCALE_W'(pixel_y);
      col1 <= pixel_x;
      row1 <= pixel_y;

      red_prod <= QPROD_W'(red_scaled) * QPROD_W'(RED_MULT);
      green_prod <= QPROD_W'(green_scaled) * QPROD_W'(GREEN_MULT);
      row_prod <= IPROD_W'(row1) * IPROD_W'(WIDTH_K);
      col2 <= col1;

      frame_index <= row_prod[INDEX_W-1:0] + INDEX_W'(col2);
      red <= (red_quot > COLOUR_MAX) ? COLOUR_MAX[COLOUR_W-1:0] : red_quot[COLOUR_W-1:0];
      green <= (green_quot > COLOUR_MAX) ? COLOUR_MAX[COLOUR_W-1:0]
                                         : green_quot[COLOUR_W-1:0];
    end
  end

endmodule

>>> rtl/triangle_coverage_shader_unit.sv
// Tests one pixel per clock against a triangle held in six 11-bit vertex registers
// (byte addresses 0 to 20 on the APB port) and returns the coverage flag, the
// framebuffer index and the red and green shades. The datapath is a three-stage
// pipeline: offsets and bounding box, then the multipliers, then the edge sums and
// colour saturation. A new pixel can be taken every cycle while the result side
// does not stall; a stall on the result side holds the whole pipeline in place.
// Vertices may only be changed while no pixel is in flight.
module triangle_coverage_shader_unit
  import tcs_pkg::*;
#(
  parameter int unsigned VIEW_WIDTH = DEFAULT_VIEW_WIDTH,
  parameter int unsigned VIEW_HEIGHT = DEFAULT_VIEW_HEIGHT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  input  logic                pixel_valid,
  output logic                pixel_ready,
  input  logic [COORD_W-1:0]  pixel_x,
  input  logic [COORD_W-1:0]  pixel_y,
  output logic                result_valid,
  input  logic                result_ready,
  output logic                covered,
  output logic [INDEX_W-1:0]  frame_index,
  output logic [COLOUR_W-1:0] red,
  output logic [COLOUR_W-1:0] green
);

  tcs_tri_t            tri_cfg;
  logic                advance;
  logic                valid1;
  logic                valid2;
  logic                valid3;
  logic                hit;
  logic [COLOUR_W-1:0] red_raw;
  logic [COLOUR_W-1:0] green_raw;

  assign pready = 1'b1;
  assign advance = !valid3 || result_ready;
  assign pixel_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
    end else if (advance) begin
      valid1 <= pixel_valid;
      valid2 <= valid1;
      valid3 <= valid2;
    end
  end

  tcs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .tri_cfg (tri_cfg)
  );

  tcs_edge_pipe u_edge (
    .clk     (clk),
    .en      (advance),
    .pixel_x (pixel_x),
    .pixel_y (pixel_y),
    .tri_cfg (tri_cfg),
    .covered (hit)
  );

  tcs_shade_pipe #(
    .VIEW_WIDTH  (VIEW_WIDTH),
    .VIEW_HEIGHT (VIEW_HEIGHT)
  ) u_shade (
    .clk         (clk),
    .en          (advance),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .frame_index (frame_index),
    .red         (red_raw),
    .green       (green_raw)
  );

  assign result_valid = valid3;
  assign covered = hit;
  assign red = hit ? red_raw : '0;
  assign green = hit ? green_raw : '0;

endmodule

>>> rtl/tcs_checker.sv
module tcs_checker
  import tcs_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                pready,
  input logic                pixel_ready,
  input logic                result_valid,
  input logic                result_ready,
  input logic                covered,
  input logic [INDEX_W-1:0]  frame_index,
  input logic [COLOUR_W-1:0] red,
  input logic [COLOUR_W-1:0] green
);

  a_pready_high: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(covered) &&
      $stable(frame_index) && $stable(red) && $stable(green))
    else $error("stalled result item changed");

  a_uncovered_black: assert property (@(posedge clk) disable iff (rst)
    result_valid && !covered |-> red == '0 && green == '0)
    else $error("uncovered item has colour");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> pixel_ready)
    else $error("input stalled with empty output");

endmodule

bind triangle_coverage_shader_unit tcs_checker u_checker (.*);
